// ----- rtl/vna_pkg.sv -----
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and constants of the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

    localparam int VERTEX_COUNT_DEF = 1024;
    localparam int ACCUM_BITS_DEF   = 48;
    localparam int COORD_BITS       = 20;
    localparam int IDX_W            = 10;
    localparam int NORM_BITS        = 24;
    localparam int Q_W              = 16;
    localparam int CNT_W            = 16;

    typedef enum logic [1:0] {
        CMD_CLEAR       = 2'd0,
        CMD_WRITE_POS   = 2'd1,
        CMD_ACCUM_TRI   = 2'd2,
        CMD_READ_NORMAL = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                    command;
        logic [IDX_W-1:0]        vertex_index;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic [IDX_W-1:0]        corner_a;
        logic [IDX_W-1:0]        corner_b;
        logic [IDX_W-1:0]        corner_c;
    } vna_in_t;

    typedef struct packed {
        logic signed [Q_W-1:0] normal_x;
        logic signed [Q_W-1:0] normal_y;
        logic signed [Q_W-1:0] normal_z;
        logic                  zero_length;
    } vna_out_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_PRD, ST_EDGE, ST_MUL, ST_DIFF,
        ST_ACC_RD, ST_ACC_WR, ST_ARD, ST_AMAG, ST_NORM, ST_SQ, ST_SUM,
        ST_SQRT, ST_DIVLD, ST_DIV, ST_DIVST, ST_OUT
    } state_t;

    typedef struct packed {
        logic             in_load;
        logic             pos_we;
        logic             cap_en;
        logic             edge_en;
        logic             mul_en;
        logic             mul_sq;
        logic             diff_en;
        logic             acc_rsel_idx;
        logic             acc_we;
        logic             acc_clr;
        logic             mag_en;
        logic             norm_en;
        logic             sum_en;
        logic             sqrt_en;
        logic             div_init;
        logic             div_en;
        logic             div_store;
        logic             out_load;
        logic [CNT_W-1:0] step;
        logic [1:0]       comp;
    } vna_ctl_t;

    typedef struct packed {
        cmd_t cmd;
        logic idx_ok;
        logic tri_ok;
        logic mag_zero;
        logic norm_high;
        logic norm_low;
        logic out_busy;
    } vna_sts_t;

endpackage

// ----- rtl/vertex_normal_accumulator.sv -----
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// Vertex position store with per-vertex normal accumulators.
//
//   channel   ports                     carries
//   input     s_valid s_ready s_data    command word
//   result    m_valid m_ready m_data    normalised normal, read normal only
//
// write position is a single write to the position store; accumulate triangle
// runs three read-modify-writes of the accumulator RAM after one shared
// multiplier runs six products; read normal runs a normalising shift to 24
// bits, a 25-step square root and three 17-step divides.
// clear and reset run a sweep through every accumulator RAM entry with
// s_ready low.
// a finished result waits in the output register; the next word is taken
// meanwhile, and a read normal stalls only at its final load.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator #(
    parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF,
    parameter int ACCUM_BITS   = vna_pkg::ACCUM_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  vna_pkg::vna_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output vna_pkg::vna_out_t m_data
);

    vna_pkg::vna_ctl_t ctl;
    vna_pkg::vna_sts_t sts;

    vna_ctrl #(.VERTEX_COUNT(VERTEX_COUNT)) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    vna_datapath #(.VERTEX_COUNT(VERTEX_COUNT), .ACCUM_BITS(ACCUM_BITS)) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .ctl     (ctl),
        .sts     (sts)
    );

endmodule

// ----- rtl/vna_ram.sv -----
// ----------------------------------------------------------------------------
// vna_ram
// Simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module vna_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/vna_ctrl.sv -----
// ----------------------------------------------------------------------------
// vna_ctrl
// Command sequencer: clearing sweep, triangle and normalise sequences.
// ----------------------------------------------------------------------------
module vna_ctrl #(
    parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  vna_pkg::vna_sts_t sts,
    output vna_pkg::vna_ctl_t ctl
);

    localparam logic [vna_pkg::CNT_W-1:0] LAST = vna_pkg::CNT_W'(VERTEX_COUNT - 1);

    vna_pkg::state_t state_reg, state_next;
    logic [vna_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0] comp_reg, comp_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vna_pkg::ST_CLEAR;
            cnt_reg   <= '0;
            comp_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        ctl        = '0;
        ctl.step   = cnt_reg;
        ctl.comp   = comp_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            vna_pkg::ST_CLEAR: begin
                ctl.acc_clr = 1'b1;
                if (cnt_reg == LAST) begin
                    cnt_next   = '0;
                    state_next = vna_pkg::ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            vna_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.in_load = 1'b1;
                    state_next  = vna_pkg::ST_DISPATCH;
                end
            end
            vna_pkg::ST_DISPATCH: begin
                cnt_next  = '0;
                comp_next = '0;
                unique case (sts.cmd)
                    vna_pkg::CMD_CLEAR: state_next = vna_pkg::ST_CLEAR;
                    vna_pkg::CMD_WRITE_POS: begin
                        ctl.pos_we = sts.idx_ok;
                        state_next = vna_pkg::ST_IDLE;
                    end
                    vna_pkg::CMD_ACCUM_TRI:
                        state_next = sts.tri_ok ? vna_pkg::ST_PRD : vna_pkg::ST_IDLE;
                    default:
                        state_next = sts.idx_ok ? vna_pkg::ST_ARD : vna_pkg::ST_OUT;
                endcase
            end
            vna_pkg::ST_PRD: begin
                ctl.cap_en = 1'b1;
                if (cnt_reg == vna_pkg::CNT_W'(3)) begin
                    cnt_next   = '0;
                    state_next = vna_pkg::ST_EDGE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            vna_pkg::ST_EDGE: begin
                ctl.edge_en = 1'b1;
                state_next  = vna_pkg::ST_MUL;
            end
            vna_pkg::ST_MUL: begin
                ctl.mul_en = 1'b1;
                if (cnt_reg == vna_pkg::CNT_W'(5)) begin
                    cnt_next   = '0;
                    state_next = vna_pkg::ST_DIFF;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            vna_pkg::ST_DIFF: begin
                ctl.diff_en = 1'b1;
                comp_next   = '0;
                state_next  = vna_pkg::ST_ACC_RD;
            end
            vna_pkg::ST_ACC_RD: begin
                state_next = vna_pkg::ST_ACC_WR;
            end
            vna_pkg::ST_ACC_WR: begin
                ctl.acc_we = 1'b1;
                if (comp_reg == 2'd2) begin
                    comp_next  = '0;
                    state_next = vna_pkg::ST_IDLE;
                end else begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = vna_pkg::ST_ACC_RD;
                end
            end
            vna_pkg::ST_ARD: begin
                ctl.acc_rsel_idx = 1'b1;
                state_next       = vna_pkg::ST_AMAG;
            end
            vna_pkg::ST_AMAG: begin
                ctl.mag_en = 1'b1;
                state_next = vna_pkg::ST_NORM;
            end
            vna_pkg::ST_NORM: begin
                cnt_next = '0;
                if (sts.mag_zero) begin
                    state_next = vna_pkg::ST_OUT;
                end else if (sts.norm_high || sts.norm_low) begin
                    ctl.norm_en = 1'b1;
                end else begin
                    state_next = vna_pkg::ST_SQ;
                end
            end
            vna_pkg::ST_SQ: begin
                ctl.mul_en = 1'b1;
                ctl.mul_sq = 1'b1;
                if (cnt_reg == vna_pkg::CNT_W'(2)) begin
                    cnt_next   = '0;
                    state_next = vna_pkg::ST_SUM;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            vna_pkg::ST_SUM: begin
                ctl.sum_en = 1'b1;
                cnt_next   = '0;
                state_next = vna_pkg::ST_SQRT;
            end
            vna_pkg::ST_SQRT: begin
                ctl.sqrt_en = 1'b1;
                if (cnt_reg == vna_pkg::CNT_W'(24)) begin
                    cnt_next   = '0;
                    comp_next  = '0;
                    state_next = vna_pkg::ST_DIVLD;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            vna_pkg::ST_DIVLD: begin
                ctl.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = vna_pkg::ST_DIV;
            end
            vna_pkg::ST_DIV: begin
                ctl.div_en = 1'b1;
                if (cnt_reg == vna_pkg::CNT_W'(16)) begin
                    cnt_next   = '0;
                    state_next = vna_pkg::ST_DIVST;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            vna_pkg::ST_DIVST: begin
                ctl.div_store = 1'b1;
                if (comp_reg == 2'd2) begin
                    comp_next  = '0;
                    state_next = vna_pkg::ST_OUT;
                end else begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = vna_pkg::ST_DIVLD;
                end
            end
            vna_pkg::ST_OUT: begin
                if (!sts.out_busy) begin
                    ctl.out_load = 1'b1;
                    state_next   = vna_pkg::ST_IDLE;
                end
            end
            default: state_next = vna_pkg::ST_IDLE;
        endcase
    end

endmodule

// ----- rtl/vna_datapath.sv -----
// ----------------------------------------------------------------------------
// vna_datapath
// Position and accumulator stores, cross product, normalise, square root
// and divide units, output word register.
// ----------------------------------------------------------------------------
module vna_datapath #(
    parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF,
    parameter int ACCUM_BITS   = vna_pkg::ACCUM_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  vna_pkg::vna_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output vna_pkg::vna_out_t m_data,
    input  vna_pkg::vna_ctl_t ctl,
    output vna_pkg::vna_sts_t sts
);

    localparam int AW = $clog2(VERTEX_COUNT);
    localparam int C  = vna_pkg::COORD_BITS;
    localparam int A  = ACCUM_BITS;
    localparam int NW = 2 * (C + 1) + 1;
    localparam int SW = ((A > NW) ? A : NW) + 1;
    localparam int IW = vna_pkg::IDX_W;
    localparam logic signed [SW-1:0] ACC_HI = {{(SW-A+1){1'b0}}, {(A-1){1'b1}}};
    localparam logic signed [SW-1:0] ACC_LO = {{(SW-A+1){1'b1}}, {(A-1){1'b0}}};
    localparam logic [A:0] NORM_LIMIT = (A+1)'(1) << vna_pkg::NORM_BITS;

    function automatic logic [AW-1:0] to_addr(input logic [IW-1:0] i);
        logic [IW+AW-1:0] e;
        e = (IW+AW)'(i);
        return e[AW-1:0];
    endfunction

    function automatic logic in_range(input logic [IW-1:0] i);
        return 32'(i) < VERTEX_COUNT;
    endfunction

    function automatic logic signed [C-1:0] coord(input logic [3*C-1:0] w, input int k);
        return $signed(w[(3-k)*C-1 -: C]);
    endfunction

    function automatic logic [A-1:0] acc_sat(input logic signed [A-1:0] acc,
                                             input logic signed [NW-1:0] n);
        logic signed [SW-1:0] s;
        s = SW'(acc) + SW'(n);
        if (s > ACC_HI) begin
            s = ACC_HI;
        end else if (s < ACC_LO) begin
            s = ACC_LO;
        end
        return s[A-1:0];
    endfunction

    vna_pkg::vna_in_t in_reg;

    logic [IW-1:0]    corner;
    logic [3*C-1:0]   pos_rdata;
    logic [3*A-1:0]   acc_rdata;
    logic [3*A-1:0]   acc_wdata;
    logic [AW-1:0]    acc_waddr;
    logic [AW-1:0]    acc_raddr;

    logic [3*C-1:0]        p_reg [3];
    logic signed [C:0]     u_reg [3];
    logic signed [C:0]     v_reg [3];
    logic signed [49:0]    prod_reg [6];
    logic signed [NW-1:0]  n_reg [3];
    logic [A-1:0]          mag_reg [3];
    logic [2:0]            sign_reg;
    logic [A-1:0]          mag_or;

    logic signed [24:0] opa, opb;
    logic signed [49:0] product;

    logic [49:0] rad_reg;
    logic [26:0] rem_reg;
    logic [24:0] root_reg;
    logic [28:0] rem_t, trial;

    logic [24:0] drem_reg;
    logic [16:0] dnum_reg;
    logic [16:0] quot_reg;
    logic [39:0] num;
    logic [25:0] dt;
    logic [15:0] qc;

    logic signed [vna_pkg::Q_W-1:0] nrm_reg [3];
    logic                           m_valid_reg;
    vna_pkg::vna_out_t              m_data_reg;
    logic                           zero_out;

    always_ff @(posedge aclk) begin
        if (ctl.in_load) begin
            in_reg <= s_data;
        end
    end

    always_comb begin
        case (ctl.acc_rsel_idx ? 2'd3 : ctl.comp)
            2'd0:    corner = in_reg.corner_a;
            2'd1:    corner = in_reg.corner_b;
            2'd2:    corner = in_reg.corner_c;
            default: corner = in_reg.vertex_index;
        endcase
    end

    // position store, corners read in turn
    logic [IW-1:0] pos_corner;
    always_comb begin
        case (ctl.step[1:0])
            2'd0:    pos_corner = in_reg.corner_a;
            2'd1:    pos_corner = in_reg.corner_b;
            default: pos_corner = in_reg.corner_c;
        endcase
    end

    vna_ram #(.WIDTH(3*C), .DEPTH(VERTEX_COUNT)) u_pos_ram (
        .aclk  (aclk),
        .we    (ctl.pos_we),
        .waddr (to_addr(in_reg.vertex_index)),
        .wdata ({in_reg.pos_x, in_reg.pos_y, in_reg.pos_z}),
        .raddr (to_addr(pos_corner)),
        .rdata (pos_rdata)
    );

    assign acc_raddr = to_addr(corner);
    assign acc_waddr = ctl.acc_clr ? ctl.step[AW-1:0] : to_addr(corner);
    assign acc_wdata = ctl.acc_clr ? '0 :
        {acc_sat($signed(acc_rdata[3*A-1 -: A]), n_reg[0]),
         acc_sat($signed(acc_rdata[2*A-1 -: A]), n_reg[1]),
         acc_sat($signed(acc_rdata[A-1 -: A]),   n_reg[2])};

    vna_ram #(.WIDTH(3*A), .DEPTH(VERTEX_COUNT)) u_acc_ram (
        .aclk  (aclk),
        .we    (ctl.acc_we | ctl.acc_clr),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    // shared multiplier
    always_comb begin
        opa = '0;
        opb = '0;
        if (ctl.mul_sq) begin
            case (ctl.step[1:0])
                2'd0:    opa = {1'b0, mag_reg[0][23:0]};
                2'd1:    opa = {1'b0, mag_reg[1][23:0]};
                default: opa = {1'b0, mag_reg[2][23:0]};
            endcase
            opb = opa;
        end else begin
            case (ctl.step[2:0])
                3'd0: begin opa = 25'(u_reg[1]); opb = 25'(v_reg[2]); end
                3'd1: begin opa = 25'(u_reg[2]); opb = 25'(v_reg[1]); end
                3'd2: begin opa = 25'(u_reg[2]); opb = 25'(v_reg[0]); end
                3'd3: begin opa = 25'(u_reg[0]); opb = 25'(v_reg[2]); end
                3'd4: begin opa = 25'(u_reg[0]); opb = 25'(v_reg[1]); end
                default: begin opa = 25'(u_reg[1]); opb = 25'(v_reg[0]); end
            endcase
        end
        product = opa * opb;
    end

    always_ff @(posedge aclk) begin
        if (ctl.cap_en) begin
            case (ctl.step[1:0])
                2'd1:    p_reg[0] <= pos_rdata;
                2'd2:    p_reg[1] <= pos_rdata;
                2'd3:    p_reg[2] <= pos_rdata;
                default: ;
            endcase
        end
        if (ctl.edge_en) begin
            for (int k = 0; k < 3; k++) begin
                u_reg[k] <= (C+1)'(coord(p_reg[2], k)) - (C+1)'(coord(p_reg[0], k));
                v_reg[k] <= (C+1)'(coord(p_reg[1], k)) - (C+1)'(coord(p_reg[0], k));
            end
        end
        if (ctl.mul_en) begin
            prod_reg[ctl.step[2:0]] <= product;
        end
        if (ctl.diff_en) begin
            n_reg[0] <= NW'(prod_reg[0]) - NW'(prod_reg[1]);
            n_reg[1] <= NW'(prod_reg[2]) - NW'(prod_reg[3]);
            n_reg[2] <= NW'(prod_reg[4]) - NW'(prod_reg[5]);
        end
    end

    // magnitudes and normalising shift
    assign mag_or = mag_reg[0] | mag_reg[1] | mag_reg[2];

    always_ff @(posedge aclk) begin
        if (ctl.mag_en) begin
            for (int k = 0; k < 3; k++) begin
                sign_reg[2-k] <= acc_rdata[(3-k)*A-1];
                mag_reg[k]    <= acc_rdata[(3-k)*A-1] ?
                                 (~acc_rdata[(3-k)*A-1 -: A] + 1'b1) :
                                 acc_rdata[(3-k)*A-1 -: A];
            end
        end else if (ctl.norm_en) begin
            for (int k = 0; k < 3; k++) begin
                if (sts.norm_high) begin
                    mag_reg[k] <= mag_reg[k] >> 1;
                end else begin
                    mag_reg[k] <= mag_reg[k] << 1;
                end
            end
        end
    end

    // square root, one result bit a cycle
    assign rem_t = {rem_reg[26:0], rad_reg[49:48]};
    assign trial = {2'b00, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (ctl.sum_en) begin
            rad_reg  <= {2'b00, prod_reg[0][47:0]} + {2'b00, prod_reg[1][47:0]}
                      + {2'b00, prod_reg[2][47:0]};
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (ctl.sqrt_en) begin
            rad_reg <= rad_reg << 2;
            if (rem_t >= trial) begin
                rem_reg  <= 27'(rem_t - trial);
                root_reg <= {root_reg[23:0], 1'b1};
            end else begin
                rem_reg  <= 27'(rem_t);
                root_reg <= {root_reg[23:0], 1'b0};
            end
        end
    end

    // restoring divide, one quotient bit a cycle
    logic [23:0] mag_sel;
    always_comb begin
        case (ctl.comp)
            2'd0:    mag_sel = mag_reg[0][23:0];
            2'd1:    mag_sel = mag_reg[1][23:0];
            default: mag_sel = mag_reg[2][23:0];
        endcase
    end

    assign num = {1'b0, mag_sel, 15'd0} + 40'(root_reg >> 1);
    assign dt  = {drem_reg, dnum_reg[16]};
    assign qc  = (quot_reg > 17'd32767) ? 16'd32767 : quot_reg[15:0];

    always_ff @(posedge aclk) begin
        if (ctl.div_init) begin
            drem_reg <= {2'b00, num[39:17]};
            dnum_reg <= num[16:0];
            quot_reg <= '0;
        end else if (ctl.div_en) begin
            dnum_reg <= dnum_reg << 1;
            if (dt >= {1'b0, root_reg}) begin
                drem_reg <= 25'(dt - {1'b0, root_reg});
                quot_reg <= {quot_reg[15:0], 1'b1};
            end else begin
                drem_reg <= dt[24:0];
                quot_reg <= {quot_reg[15:0], 1'b0};
            end
        end
        if (ctl.div_store) begin
            case (ctl.comp)
                2'd0:    nrm_reg[0] <= sign_reg[2] ? -$signed(qc) : $signed(qc);
                2'd1:    nrm_reg[1] <= sign_reg[1] ? -$signed(qc) : $signed(qc);
                default: nrm_reg[2] <= sign_reg[0] ? -$signed(qc) : $signed(qc);
            endcase
        end
    end

    // output word register
    assign zero_out = !in_range(in_reg.vertex_index) || (mag_or == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            if (zero_out) begin
                m_data_reg <= '{normal_x: '0, normal_y: '0, normal_z: '0, zero_length: 1'b1};
            end else begin
                m_data_reg <= '{normal_x: nrm_reg[0], normal_y: nrm_reg[1],
                                normal_z: nrm_reg[2], zero_length: 1'b0};
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        sts.cmd       = in_reg.command;
        sts.idx_ok    = in_range(in_reg.vertex_index);
        sts.tri_ok    = in_range(in_reg.corner_a) && in_range(in_reg.corner_b)
                      && in_range(in_reg.corner_c);
        sts.mag_zero  = (mag_or == '0);
        sts.norm_high = ({1'b0, mag_or} >= NORM_LIMIT);
        sts.norm_low  = !mag_or[vna_pkg::NORM_BITS-1];
        sts.out_busy  = m_valid_reg && !m_ready;
    end

endmodule
